// ----- src/adaptive_penalty_controller_core_defines.svh -----
// Shared assertion macros for the penalty controller.
`ifndef ADAPTIVE_PENALTY_CONTROLLER_CORE_DEFINES_SVH
`define ADAPTIVE_PENALTY_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define APC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apc same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define APC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apc next-cycle check failed");

`endif

// ----- src/apc_pkg.sv -----
`default_nettype none

package apc_pkg;

    localparam int Window = 100;
    localparam int CntW   = $clog2(Window + 1);
    localparam int PenW   = 33;

    localparam logic [PenW-1:0] PenCap   = 33'd6553600000;
    localparam logic [PenW-1:0] PenFloor = 33'd6554;
    localparam logic [PenW-1:0] PenOne   = 33'd65536;

    // wide enough for 1000*count + 50*Window and target*Window
    localparam int CmpW = $clog2(1100 * Window + 1) + 1;
    localparam logic [CmpW-1:0] BandTerm = CmpW'(50 * Window);

    localparam logic [1:0] KindRecord = 2'd0;
    localparam logic [1:0] KindAdjust = 2'd1;
    localparam logic [1:0] KindReload = 2'd2;

    localparam logic [1:0] CfgTarget  = 2'd0;
    localparam logic [1:0] CfgCapInit = 2'd1;
    localparam logic [1:0] CfgDurInit = 2'd2;

    // 2^16 = 5*K1 + 1, 2^32 = 5*K2 + 1
    localparam logic [33:0] K1     = 34'd13107;
    localparam logic [33:0] K2     = 34'd858993459;
    localparam logic [35:0] Recip5 = 36'd52429;

    // floor(x/5): fold 16-bit digits (each weight is 1 mod 5), then a
    // reciprocal multiply on the small digit sum (exact below 2^18)
    function automatic logic [33:0] div5(input logic [35:0] x);
        logic [17:0] s;
        logic [35:0] p;
        logic [33:0] q;
        s = 18'(x[15:0]) + 18'(x[31:16]) + 18'(x[35:32]);
        p = 36'(s) * Recip5;
        q = 34'(x[31:16]) * K1 + 34'(x[35:32]) * K2 + 34'(p[35:18]);
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- src/apc_window.sv -----
`default_nettype none

module apc_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      shift_en,
    input  logic                      bit_in,
    output logic [apc_pkg::CntW-1:0]  count,
    output logic [apc_pkg::CntW-1:0]  count_next
);
    import apc_pkg::*;

    logic [Window-1:0] win_reg;
    logic [Window-1:0] win_next;
    logic [CntW-1:0]   cnt_reg;
    logic [CntW-1:0]   cnt_next;

    // newest outcome at bit 0, oldest drops out of the top
    always_comb
    begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        if (shift_en)
        begin
            win_next = (win_reg << 1) | Window'(bit_in);
            cnt_next = cnt_reg - CntW'(win_reg[Window-1]) + CntW'(bit_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '1;
            cnt_reg <= CntW'(Window);
        end
        else
        begin
            win_reg <= win_next;
            cnt_reg <= cnt_next;
        end
    end

    assign count      = cnt_reg;
    assign count_next = cnt_next;

endmodule

`default_nettype wire

// ----- src/apc_penalty_adjust.sv -----
`default_nettype none

module apc_penalty_adjust (
    input  logic [apc_pkg::PenW-1:0] weight,
    input  logic [apc_pkg::CntW-1:0] count,
    input  logic [9:0]               target,
    output logic [apc_pkg::PenW-1:0] weight_adj
);
    import apc_pkg::*;

    logic [CmpW-1:0] scaled_cnt;
    logic [CmpW-1:0] tgt;
    logic            raise;
    logic            lower;
    logic [34:0]     up_sum;
    logic [PenW-1:0] up_w;
    logic [37:0]     prod17;
    logic [33:0]     down_q;
    logic [PenW-1:0] down_w;

    assign scaled_cnt = CmpW'(count) * CmpW'(1000);
    assign tgt        = CmpW'(target) * CmpW'(Window);
    assign raise      = (scaled_cnt + BandTerm) < tgt;
    assign lower      = scaled_cnt > (tgt + BandTerm);

    // floor(6w/5) = w + floor(w/5)
    assign up_sum = 35'(weight) + 35'(div5(36'(weight)));
    assign up_w   = (up_sum > 35'(PenCap)) ? PenCap : up_sum[PenW-1:0];

    // floor(17w/20) = floor(floor(17w/4)/5)
    assign prod17 = 38'(weight) * 38'(17);
    assign down_q = div5(prod17[37:2]);
    assign down_w = (down_q < 34'(PenFloor)) ? PenFloor : down_q[PenW-1:0];

    always_comb
    begin
        priority if (raise && (weight < PenCap))
            weight_adj = up_w;
        else if (lower && (weight > PenFloor))
            weight_adj = down_w;
        else
            weight_adj = weight;
    end

endmodule

`default_nettype wire

// ----- src/adaptive_penalty_controller_core.sv -----
// Output: a result is registered on the master side from its transfer in, or held in the skid while m_tready is low.
// Throughput: one item per cycle while s_tready is high; the state update is a single registered pass.
// A two-deep output (result register plus skid) keeps one more item in flight.
// Reset: windows all feasible, counts at full window, both weights 1.0,
// config registers at their defaults; no clearing pass.
`default_nettype none
`include "adaptive_penalty_controller_core_defines.svh"

module adaptive_penalty_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] load_ok, [1] duration_ok, [7:2] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [32:0] capacity_penalty, [65:33] duration_penalty,
                                   // [72:66] load_feasible_count,
                                   // [79:73] duration_feasible_count
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [32:0] cfg_data
);
    import apc_pkg::*;

    typedef struct packed {
        logic [6:0]      dur_cnt;
        logic [6:0]      load_cnt;
        logic [PenW-1:0] dur_pen;
        logic [PenW-1:0] cap_pen;
    } result_t;

    logic [9:0]      target_reg;
    logic [PenW-1:0] cap_init_reg;
    logic [PenW-1:0] dur_init_reg;
    logic [PenW-1:0] cap_w_reg;
    logic [PenW-1:0] cap_w_next;
    logic [PenW-1:0] dur_w_reg;
    logic [PenW-1:0] dur_w_next;
    logic [PenW-1:0] cap_w_adj;
    logic [PenW-1:0] dur_w_adj;

    logic            out_valid_reg;
    logic            skid_valid_reg;
    result_t         out_data_reg;
    result_t         skid_data_reg;
    result_t         result;

    logic            in_xfer;
    logic            out_pop;
    logic            rec_en;
    logic [CntW-1:0] load_cnt;
    logic [CntW-1:0] load_cnt_next;
    logic [CntW-1:0] dur_cnt;
    logic [CntW-1:0] dur_cnt_next;

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_pop  = out_valid_reg && m_tready;
    assign rec_en   = in_xfer && (s_tuser == KindRecord);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= 10'd200;
            cap_init_reg <= PenOne;
            dur_init_reg <= PenOne;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgTarget:  target_reg   <= cfg_data[9:0];
                CfgCapInit: cap_init_reg <= cfg_data;
                CfgDurInit: dur_init_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    apc_window u_load_win (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (rec_en),
        .bit_in     (s_tdata[0]),
        .count      (load_cnt),
        .count_next (load_cnt_next)
    );

    apc_window u_dur_win (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (rec_en),
        .bit_in     (s_tdata[1]),
        .count      (dur_cnt),
        .count_next (dur_cnt_next)
    );

    apc_penalty_adjust u_cap_adj (
        .weight     (cap_w_reg),
        .count      (load_cnt),
        .target     (target_reg),
        .weight_adj (cap_w_adj)
    );

    apc_penalty_adjust u_dur_adj (
        .weight     (dur_w_reg),
        .count      (dur_cnt),
        .target     (target_reg),
        .weight_adj (dur_w_adj)
    );

    always_comb
    begin
        cap_w_next = cap_w_reg;
        dur_w_next = dur_w_reg;
        if (in_xfer)
        begin
            unique case (s_tuser)
                KindAdjust:
                begin
                    cap_w_next = cap_w_adj;
                    dur_w_next = dur_w_adj;
                end
                KindReload:
                begin
                    cap_w_next = cap_init_reg;
                    dur_w_next = dur_init_reg;
                end
                default: ;
            endcase
        end
    end

    assign result.cap_pen  = cap_w_next;
    assign result.dur_pen  = dur_w_next;
    assign result.load_cnt = 7'(load_cnt_next);
    assign result.dur_cnt  = 7'(dur_cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_w_reg <= PenOne;
            dur_w_reg <= PenOne;
        end
        else
        begin
            cap_w_reg <= cap_w_next;
            dur_w_reg <= dur_w_next;
        end
    end

    // result register with a one-entry skid behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_pop)
                    skid_valid_reg <= 1'b0;
            end
            else if (in_xfer)
            begin
                if (out_valid_reg && !m_tready)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
                out_data_reg <= skid_data_reg;
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !m_tready)
                skid_data_reg <= result;
            else
                out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `APC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `APC_ASSERT_NOW(a_count_in_range, 1'b1, (load_cnt <= CntW'(Window)) && (dur_cnt <= CntW'(Window)))
    `APC_ASSERT_NEXT(a_weights_hold, !in_xfer, $stable(cap_w_reg) && $stable(dur_w_reg))
    `APC_ASSERT_NEXT(a_stall_fills_skid, in_xfer && out_valid_reg && !m_tready, skid_valid_reg)

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
    import apc_pkg::*;

    localparam logic [1:0] KindNone = 2'd3;  // no-op kind, reports current state
    localparam logic [1:0] CfgNone  = 2'd3;  // unmapped register index

    localparam int GapMax     = 5;
    localparam int HoldCycles = 60;
    localparam int StallLimit = 2000;
    localparam int Phases     = 8;
    localparam int PhaseItems = 160;

    // matches m_tdata, lowest field last
    typedef struct packed {
        logic [6:0]  dur_cnt;
        logic [6:0]  load_cnt;
        logic [32:0] dur_pen;
        logic [32:0] cap_pen;
    } penalty_report_t;

    class penalty_scoreboard;
        bit              load_hist[Window];
        bit              dur_hist[Window];
        int              slot;
        int              load_cnt;
        int              dur_cnt;
        logic [32:0]     cap_w;
        logic [32:0]     dur_w;
        logic [9:0]      target_pm;
        logic [32:0]     cap_init;
        logic [32:0]     dur_init;
        penalty_report_t expected_q[$];
        int              errors;

        function new();
            foreach (load_hist[i]) load_hist[i] = 1'b1;
            foreach (dur_hist[i]) dur_hist[i] = 1'b1;
            slot      = 0;
            load_cnt  = Window;
            dur_cnt   = Window;
            cap_w     = PenOne;
            dur_w     = PenOne;
            target_pm = 10'd200;
            cap_init  = PenOne;
            dur_init  = PenOne;
            errors    = 0;
        endfunction

        // raise by 1.2 below the band, lower by 0.85 above it
        function logic [32:0] adjusted(logic [32:0] w, int cnt);
            longint          lhs;
            longint          tgt;
            longint          band;
            longint unsigned scaled;
            lhs  = longint'(cnt) * 1000;
            tgt  = longint'(target_pm) * Window;
            band = 50 * Window;
            if (lhs + band < tgt && w < PenCap)
            begin
                scaled = 64'(w) * 6 / 5;
                return (scaled > 64'(PenCap)) ? PenCap : scaled[32:0];
            end
            if (lhs > tgt + band && w > PenFloor)
            begin
                scaled = 64'(w) * 17 / 20;
                return (scaled < 64'(PenFloor)) ? PenFloor : scaled[32:0];
            end
            return w;
        endfunction

        function void set_reg(logic [1:0] idx, logic [32:0] val);
            case (idx)
                CfgTarget:  target_pm = val[9:0];
                CfgCapInit: cap_init  = val;
                CfgDurInit: dur_init  = val;
                default:    ;
            endcase
        endfunction

        function void note_input(logic [1:0] kind, bit l, bit d);
            penalty_report_t r;
            case (kind)
                KindRecord:
                begin
                    load_cnt       = load_cnt - load_hist[slot] + l;
                    dur_cnt        = dur_cnt - dur_hist[slot] + d;
                    load_hist[slot] = l;
                    dur_hist[slot]  = d;
                    slot           = (slot + 1) % Window;
                end
                KindAdjust:
                begin
                    cap_w = adjusted(cap_w, load_cnt);
                    dur_w = adjusted(dur_w, dur_cnt);
                end
                KindReload:
                begin
                    cap_w = cap_init;
                    dur_w = dur_init;
                end
                default: ;
            endcase
            r.cap_pen  = cap_w;
            r.dur_pen  = dur_w;
            r.load_cnt = 7'(load_cnt);
            r.dur_cnt  = 7'(dur_cnt);
            expected_q.insert(expected_q.size(), r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("%0t ERROR %s", $time, msg);
            errors++;
        endtask

        task check_result(penalty_report_t got);
            penalty_report_t exp_r;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            exp_r = expected_q[0];
            expected_q.delete(0);
            if (got.cap_pen !== exp_r.cap_pen)
                report($sformatf("capacity_penalty %0d, want %0d", got.cap_pen, exp_r.cap_pen));
            if (got.dur_pen !== exp_r.dur_pen)
                report($sformatf("duration_penalty %0d, want %0d", got.dur_pen, exp_r.dur_pen));
            if (got.load_cnt !== exp_r.load_cnt)
                report($sformatf("load count %0d, want %0d", got.load_cnt, exp_r.load_cnt));
            if (got.dur_cnt !== exp_r.dur_cnt)
                report($sformatf("duration count %0d, want %0d", got.dur_cnt, exp_r.dur_cnt));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [32:0] cfg_data = 33'd0;

    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;
    bit hold_results = 1'b0;

    penalty_scoreboard sb = new();

    adaptive_penalty_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // handshakes are sampled at the falling edge, when inputs and outputs are settled
    task automatic send(input logic [1:0] kind, input bit l, input bit d);
        int gap;
        bit taken;
        gap = send_gaps ? $urandom_range(0, GapMax) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, d, l};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
        sb.note_input(kind, l, d);
    endtask

    // drop valid and wait for the block to drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // caller lowers cfg_we after the last write of a batch
    task automatic write_reg(input logic [1:0] idx, input logic [32:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    function automatic logic [32:0] pick_weight(int sel);
        longint unsigned span;
        span = 64'(PenCap) - 64'(PenFloor) + 1;
        case (sel)
            0:       return PenFloor;
            1:       return PenCap;
            2:       return 33'd0;
            3:       return 33'h1_FFFF_FFFF;
            4:       return PenOne;
            5:       return PenCap - 33'd1;
            6:       return 33'd1;
            default: return 33'(64'(PenFloor) + {31'd0, 1'($urandom()), $urandom()} % span);
        endcase
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 5;
            2:       return 50;
            3:       return 95;
            default: return 100;
        endcase
    endfunction

    // result side
    initial
    begin : result_sink
        int              gap;
        bit              got;
        penalty_report_t word;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_results = 1'b0;
            end
            gap = recv_gaps ? $urandom_range(0, GapMax) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                got  = m_tvalid;
                word = m_tdata;
                @(posedge clk);
            end while (!got);
            sb.check_result(word);
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < StallLimit)
        begin
            @(negedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                stuck = 0;
            else
                stuck++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [1:0]  kind;
        logic [9:0]  tgt;
        int          p_load;
        int          p_dur;
        int          r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset state, each kind, all outcome pairs
        send(KindNone, 1'b0, 1'b0);
        send(KindAdjust, 1'b0, 1'b0);
        send(KindReload, 1'b0, 1'b0);
        send(KindRecord, 1'b0, 1'b0);
        send(KindRecord, 1'b1, 1'b0);
        send(KindRecord, 1'b0, 1'b1);
        send(KindRecord, 1'b1, 1'b1);
        send(KindNone, 1'b1, 1'b1);
        send(KindAdjust, 1'b1, 1'b0);

        // target above 1000, zero and oversized weights, unmapped index
        settle();
        write_reg(CfgTarget, 33'd1023);
        write_reg(CfgCapInit, 33'd0);
        write_reg(CfgDurInit, 33'h1_FFFF_FFFF);
        write_reg(CfgNone, {1'b1, $urandom()});
        cfg_we <= 1'b0;
        send(KindReload, 1'b0, 1'b1);
        send(KindAdjust, 1'b0, 1'b0);
        send(KindAdjust, 1'b0, 1'b0);
        send(KindNone, 1'b0, 1'b0);

        // weights at floor and cap with target zero
        settle();
        write_reg(CfgTarget, {23'h7F_FFFF, 10'd0});
        write_reg(CfgCapInit, PenFloor);
        write_reg(CfgDurInit, PenCap);
        cfg_we <= 1'b0;
        send(KindReload, 1'b0, 1'b0);
        send(KindAdjust, 1'b0, 1'b0);
        send(KindAdjust, 1'b0, 1'b0);
        send(KindRecord, 1'b0, 1'b0);

        for (int ph = 0; ph < Phases; ph++)
        begin
            settle();
            case (ph)
                0:       tgt = 10'd0;
                1:       tgt = 10'd1000;
                2:       tgt = 10'd1023;
                3:       tgt = 10'd200;
                4:       tgt = 10'd500;
                default: tgt = 10'($urandom_range(0, 1023));
            endcase
            write_reg(CfgTarget, {23'($urandom()), tgt});
            write_reg(CfgCapInit, pick_weight(ph));
            write_reg(CfgDurInit, pick_weight((ph + 3) % 8));
            cfg_we <= 1'b0;

            send_gaps = (ph % 3) != 1;
            recv_gaps = (ph % 4) != 2;
            if (ph == 2)
            begin
                // sender keeps offering while results back up
                send_gaps    = 1'b0;
                hold_results = 1'b1;
            end
            p_load = pick_rate();
            p_dur  = pick_rate();
            send(KindReload, 1'b0, 1'b0);
            for (int i = 0; i < PhaseItems; i++)
            begin
                if (i == PhaseItems / 2)
                begin
                    p_load = pick_rate();
                    p_dur  = pick_rate();
                end
                r = $urandom_range(0, 99);
                if (r < 60)
                    kind = KindRecord;
                else if (r < 88)
                    kind = KindAdjust;
                else if (r < 94)
                    kind = KindReload;
                else
                    kind = KindNone;
                send(kind, $urandom_range(0, 99) < p_load, $urandom_range(0, 99) < p_dur);
            end
        end

        settle();
        repeat (5) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
